### rtl/mps3_pkg.sv
// Shared types, codes and helpers for the 3-D maze path search block.
`default_nettype none
package mps3_pkg;

  localparam int CELLS   = 512;
  localparam int CELL_W  = 9;
  localparam int COORD_W = 3;
  localparam int DEPTH_W = 10;
  localparam int DIR_W   = 3;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_IDLE  = 2'd3
  } cmd_t;

  localparam logic [1:0] MARK_NONE     = 2'd0;
  localparam logic [1:0] MARK_VISITING = 2'd1;
  localparam logic [1:0] MARK_DEAD     = 2'd2;

  // neighbor order: x-1, x+1, y-1, y+1, z-1, z+1
  localparam logic [DIR_W-1:0] DIR_XM  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_XP  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_YM  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_YP  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_ZM  = 3'd4;
  localparam logic [DIR_W-1:0] DIR_ZP  = 3'd5;
  localparam logic [DIR_W-1:0] DIR_END = 3'd6;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD_WAIT,
    ST_START,
    ST_DIR,
    ST_POP_WAIT,
    ST_NB_CHK,
    ST_FOUND_WR,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic       open;
    logic [1:0] mark;
  } cell_ent_t;

  typedef struct packed {
    logic [CELL_W-1:0] loc;
    logic [DIR_W-1:0]  dir;
  } stk_ent_t;

  typedef struct packed {
    logic              ok;
    logic [CELL_W-1:0] loc;
  } nbr_t;

  // Neighbor of cell c in direction d; ok is low when it falls off the grid.
  function automatic nbr_t step_cell(input logic [CELL_W-1:0] c,
                                     input logic [DIR_W-1:0] d,
                                     input logic [COORD_W-1:0] last);
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               ok;
    x  = c[8:6];
    y  = c[5:3];
    z  = c[2:0];
    ok = 1'b0;
    unique case (d)
      DIR_XM: begin
        ok = (x != 3'd0);
        x  = x - 3'd1;
      end
      DIR_XP: begin
        ok = (x < last);
        x  = x + 3'd1;
      end
      DIR_YM: begin
        ok = (y != 3'd0);
        y  = y - 3'd1;
      end
      DIR_YP: begin
        ok = (y < last);
        y  = y + 3'd1;
      end
      DIR_ZM: begin
        ok = (z != 3'd0);
        z  = z - 3'd1;
      end
      DIR_ZP: begin
        ok = (z < last);
        z  = z + 3'd1;
      end
      default: ok = 1'b0;
    endcase
    return '{ok: ok, loc: {x, y, z}};
  endfunction

endpackage
`default_nettype wire

### rtl/mps3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mps3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/maze_path_search_3d.sv
// Top level of the 3-D maze path search block: command sequencer and its two memories.
`default_nettype none
// Grid of SIDE^3 open/wall cells with a depth-first solver from (0,0,0) to the far
// corner. A request is taken when start is high and busy is low; every request gives
// exactly one result, shown for one cycle with out_strobe, which cannot be held off.
// Write and idle requests: the result comes in the cycle after the request, and a new
// request may be taken right away. Read requests: the stack memory is read, then the
// result is registered from its read data. Solve requests: the start cell is probed
// (cell-memory read), then each search step is a probe of an in-grid neighbor
// (cell-memory read), a skip of a neighbor off the grid, or a pop (stack-memory
// read); a goal that is reached is stored, then a pass clears the visit marks.
// After reset the block is busy while it opens every cell. Cell state (open bit,
// visit mark) and the path stack each live in one memory with one read and one
// write per cycle.
module maze_path_search_3d #(
  parameter int SIDE = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output      logic       busy,
  input  wire logic [1:0] in_command,
  input  wire logic [2:0] in_cell_x,
  input  wire logic [2:0] in_cell_y,
  input  wire logic [2:0] in_cell_z,
  input  wire logic       in_cell_open,
  input  wire logic [8:0] in_path_index,
  output      logic       out_strobe,
  output      logic       out_found,
  output      logic [9:0] out_path_length,
  output      logic [2:0] out_pos_x,
  output      logic [2:0] out_pos_y,
  output      logic [2:0] out_pos_z,
  output      logic       out_entry_valid
);

  localparam logic [3:0] SIDE_V = 4'(SIDE);
  localparam logic [2:0] LAST   = 3'(SIDE - 1);
  localparam logic [8:0] GOAL   = {LAST, LAST, LAST};
  localparam logic [9:0] FULL   = 10'(mps3_pkg::CELLS);

  mps3_pkg::state_t    state_r, state_nxt;
  logic [9:0]          depth_r, depth_nxt;
  logic                found_r, found_nxt;
  logic [8:0]          top_cell_r, top_cell_nxt;
  logic [2:0]          top_dir_r, top_dir_nxt;
  logic [8:0]          nb_r, nb_nxt;
  logic [9:0]          clr_cnt_r, clr_cnt_nxt;
  logic                idx_ok_r, idx_ok_nxt;
  logic                strobe_r, strobe_nxt;
  logic [2:0]          pos_x_r, pos_x_nxt;
  logic [2:0]          pos_y_r, pos_y_nxt;
  logic [2:0]          pos_z_r, pos_z_nxt;
  logic                ev_r, ev_nxt;

  logic                cram_we;
  logic [8:0]          cram_waddr;
  mps3_pkg::cell_ent_t cram_wdata;
  logic [8:0]          cram_raddr;
  mps3_pkg::cell_ent_t cram_rdata;

  logic                sram_we;
  logic [8:0]          sram_waddr;
  mps3_pkg::stk_ent_t  sram_wdata;
  logic [8:0]          sram_raddr;
  mps3_pkg::stk_ent_t  sram_rdata;

  logic                accept;
  logic                in_range;
  mps3_pkg::nbr_t      nb;
  logic [9:0]          push_idx;
  logic [9:0]          pop_idx;
  logic [9:0]          clr_prev;

  mps3_ram #(
    .WIDTH($bits(mps3_pkg::cell_ent_t)),
    .DEPTH(mps3_pkg::CELLS)
  ) u_cell_ram (
    .clk  (clk),
    .we   (cram_we),
    .waddr(cram_waddr),
    .wdata(cram_wdata),
    .raddr(cram_raddr),
    .rdata(cram_rdata)
  );

  mps3_ram #(
    .WIDTH($bits(mps3_pkg::stk_ent_t)),
    .DEPTH(mps3_pkg::CELLS)
  ) u_stack_ram (
    .clk  (clk),
    .we   (sram_we),
    .waddr(sram_waddr),
    .wdata(sram_wdata),
    .raddr(sram_raddr),
    .rdata(sram_rdata)
  );

  assign busy     = (state_r != mps3_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = ({1'b0, in_cell_x} < SIDE_V) && ({1'b0, in_cell_y} < SIDE_V) &&
                    ({1'b0, in_cell_z} < SIDE_V);
  assign nb       = mps3_pkg::step_cell(top_cell_r, top_dir_r, LAST);
  assign push_idx = depth_r - 10'd1;
  assign pop_idx  = depth_r - 10'd2;
  assign clr_prev = clr_cnt_r - 10'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mps3_pkg::ST_INIT;
      depth_r   <= '0;
      found_r   <= 1'b0;
      clr_cnt_r <= '0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      depth_r   <= depth_nxt;
      found_r   <= found_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_cell_r <= top_cell_nxt;
    top_dir_r  <= top_dir_nxt;
    nb_r       <= nb_nxt;
    idx_ok_r   <= idx_ok_nxt;
    pos_x_r    <= pos_x_nxt;
    pos_y_r    <= pos_y_nxt;
    pos_z_r    <= pos_z_nxt;
    ev_r       <= ev_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    depth_nxt    = depth_r;
    found_nxt    = found_r;
    top_cell_nxt = top_cell_r;
    top_dir_nxt  = top_dir_r;
    nb_nxt       = nb_r;
    clr_cnt_nxt  = '0;
    idx_ok_nxt   = idx_ok_r;
    strobe_nxt   = 1'b0;
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    pos_z_nxt    = pos_z_r;
    ev_nxt       = ev_r;
    cram_we      = 1'b0;
    cram_waddr   = '0;
    cram_wdata   = '{open: 1'b1, mark: mps3_pkg::MARK_NONE};
    cram_raddr   = '0;
    sram_we      = 1'b0;
    sram_waddr   = '0;
    sram_wdata   = '{loc: top_cell_r, dir: top_dir_r};
    sram_raddr   = '0;

    unique case (state_r)
      mps3_pkg::ST_INIT: begin
        // open every cell after reset
        cram_we     = 1'b1;
        cram_waddr  = clr_cnt_r[8:0];
        clr_cnt_nxt = clr_cnt_r + 10'd1;
        if (clr_cnt_r[8:0] == '1) begin
          clr_cnt_nxt = '0;
          state_nxt   = mps3_pkg::ST_IDLE;
        end
      end

      mps3_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mps3_pkg::cmd_t'(in_command))
            mps3_pkg::CMD_WRITE: begin
              cram_we    = in_range;
              cram_waddr = {in_cell_x, in_cell_y, in_cell_z};
              cram_wdata = '{open: in_cell_open, mark: mps3_pkg::MARK_NONE};
              strobe_nxt = 1'b1;
              pos_x_nxt  = '0;
              pos_y_nxt  = '0;
              pos_z_nxt  = '0;
              ev_nxt     = 1'b0;
            end
            mps3_pkg::CMD_SOLVE: begin
              cram_raddr = '0;
              depth_nxt  = '0;
              found_nxt  = 1'b0;
              state_nxt  = mps3_pkg::ST_START;
            end
            mps3_pkg::CMD_READ: begin
              sram_raddr = in_path_index;
              idx_ok_nxt = ({1'b0, in_path_index} < depth_r);
              state_nxt  = mps3_pkg::ST_RD_WAIT;
            end
            mps3_pkg::CMD_IDLE: begin
              strobe_nxt = 1'b1;
              pos_x_nxt  = '0;
              pos_y_nxt  = '0;
              pos_z_nxt  = '0;
              ev_nxt     = 1'b0;
            end
          endcase
        end
      end

      mps3_pkg::ST_RD_WAIT: begin
        strobe_nxt = 1'b1;
        ev_nxt     = idx_ok_r;
        pos_x_nxt  = idx_ok_r ? sram_rdata.loc[8:6] : 3'd0;
        pos_y_nxt  = idx_ok_r ? sram_rdata.loc[5:3] : 3'd0;
        pos_z_nxt  = idx_ok_r ? sram_rdata.loc[2:0] : 3'd0;
        state_nxt  = mps3_pkg::ST_IDLE;
      end

      mps3_pkg::ST_START: begin
        if (cram_rdata.open) begin
          cram_we      = 1'b1;
          cram_waddr   = '0;
          cram_wdata   = '{open: 1'b1, mark: mps3_pkg::MARK_VISITING};
          top_cell_nxt = '0;
          top_dir_nxt  = mps3_pkg::DIR_XM;
          depth_nxt    = 10'd1;
          state_nxt    = mps3_pkg::ST_DIR;
        end else begin
          state_nxt = mps3_pkg::ST_CLEAR;
        end
      end

      mps3_pkg::ST_DIR: begin
        if (top_dir_r >= mps3_pkg::DIR_END) begin
          // all neighbors tried: mark dead and pop
          cram_we    = 1'b1;
          cram_waddr = top_cell_r;
          cram_wdata = '{open: 1'b1, mark: mps3_pkg::MARK_DEAD};
          depth_nxt  = push_idx;
          if (depth_r == 10'd1) begin
            state_nxt = mps3_pkg::ST_CLEAR;
          end else begin
            sram_raddr = pop_idx[8:0];
            state_nxt  = mps3_pkg::ST_POP_WAIT;
          end
        end else begin
          top_dir_nxt = top_dir_r + 3'd1;
          if (nb.ok) begin
            cram_raddr = nb.loc;
            nb_nxt     = nb.loc;
            state_nxt  = mps3_pkg::ST_NB_CHK;
          end
        end
      end

      mps3_pkg::ST_POP_WAIT: begin
        top_cell_nxt = sram_rdata.loc;
        top_dir_nxt  = sram_rdata.dir;
        state_nxt    = mps3_pkg::ST_DIR;
      end

      mps3_pkg::ST_NB_CHK: begin
        priority if (!cram_rdata.open || (cram_rdata.mark != mps3_pkg::MARK_NONE)) begin
          state_nxt = mps3_pkg::ST_DIR;
        end else if (depth_r >= FULL) begin
          depth_nxt = '0;
          state_nxt = mps3_pkg::ST_CLEAR;
        end else begin
          // spill the current top with its advanced direction, then push
          sram_we      = 1'b1;
          sram_waddr   = push_idx[8:0];
          sram_wdata   = '{loc: top_cell_r, dir: top_dir_r};
          depth_nxt    = depth_r + 10'd1;
          top_cell_nxt = nb_r;
          top_dir_nxt  = mps3_pkg::DIR_XM;
          if (nb_r == GOAL) begin
            found_nxt = 1'b1;
            state_nxt = mps3_pkg::ST_FOUND_WR;
          end else begin
            cram_we    = 1'b1;
            cram_waddr = nb_r;
            cram_wdata = '{open: 1'b1, mark: mps3_pkg::MARK_VISITING};
            state_nxt  = mps3_pkg::ST_DIR;
          end
        end
      end

      mps3_pkg::ST_FOUND_WR: begin
        sram_we    = 1'b1;
        sram_waddr = push_idx[8:0];
        sram_wdata = '{loc: top_cell_r, dir: mps3_pkg::DIR_XM};
        state_nxt  = mps3_pkg::ST_CLEAR;
      end

      mps3_pkg::ST_CLEAR: begin
        // read entry n while writing back entry n-1 with its mark cleared
        cram_raddr  = clr_cnt_r[8:0];
        cram_we     = (clr_cnt_r != 10'd0);
        cram_waddr  = clr_prev[8:0];
        cram_wdata  = '{open: cram_rdata.open, mark: mps3_pkg::MARK_NONE};
        clr_cnt_nxt = clr_cnt_r + 10'd1;
        if (clr_cnt_r == FULL) begin
          clr_cnt_nxt = '0;
          strobe_nxt  = 1'b1;
          pos_x_nxt   = '0;
          pos_y_nxt   = '0;
          pos_z_nxt   = '0;
          ev_nxt      = 1'b0;
          state_nxt   = mps3_pkg::ST_IDLE;
        end
      end

      default: state_nxt = mps3_pkg::ST_INIT;
    endcase
  end

  assign out_strobe      = strobe_r;
  assign out_found       = found_r;
  assign out_path_length = depth_r;
  assign out_pos_x       = pos_x_r;
  assign out_pos_y       = pos_y_r;
  assign out_pos_z       = pos_z_r;
  assign out_entry_valid = ev_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= FULL)
    else $error("stack depth beyond cell count");

  a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (depth_r >= 10'd2))
    else $error("found path shorter than two cells");

  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == mps3_pkg::CMD_READ)) |-> ##2 out_strobe)
    else $error("read result not delivered two cycles after request");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while sequencer busy");

endmodule
`default_nettype wire
